// ----- hw/rtl/debounce_with_pulse_pattern_timing_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the debounce and pulse pattern timing block
// Shared helpers that wrap concurrent assertions in one clocking form.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCE_WITH_PULSE_PATTERN_TIMING_ASSERT_SVH
`define DEBOUNCE_WITH_PULSE_PATTERN_TIMING_ASSERT_SVH

// Checks a property on every rising clock edge outside of reset.
`define DBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a signal keeps its value in the cycle after a condition holds.
`define DBP_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// ----- hw/rtl/dbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Debounce and pulse pattern package
// Shared types, codes and constants of the debounce and pattern timing block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbp_pkg;

    localparam int CHANNELS_DEF      = 16;
    localparam int PATTERN_SLOTS_DEF = 16;

    localparam int TICK_W  = 16;
    localparam int CHAN_W  = 4;
    localparam int COUNT_W = 5;
    localparam int INDEX_W = 4;
    localparam int DUR_W   = 13;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'h0000;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET  = 16'hFFFF;
    localparam logic [CFG_W-1:0] ENABLE_RESET   = 16'h0000;

    // Division by ten of a 16-bit value: (x * 0xCCCD) >> 19 is exact.
    localparam logic [TICK_W-1:0] DIV10_MUL   = 16'hCCCD;
    localparam int                DIV10_SHIFT = 19;

    typedef enum logic [2:0] {
        PH_UNDET   = 3'd0,
        PH_LOW     = 3'd1,
        PH_HIGH    = 3'd2,
        PH_RISING  = 3'd3,
        PH_FALLING = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_RISE = 2'd1,
        EV_FALL = 2'd2
    } t_edge;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HIGH = 2'd1,
        MODE_LOW  = 2'd2
    } t_mode;

    typedef struct packed {
        t_phase              phase;
        logic [TICK_W-1:0]   change_time;
    } t_chan_state;

    localparam t_chan_state CHAN_RESET = '{phase: PH_UNDET, change_time: '0};

    // Request from the debounce stage to the pattern unit.
    typedef struct packed {
        logic                commit;
        logic                in_range;
        logic                enabled;
        logic                edge_hit;
        t_mode               start_mode;
        logic [CHAN_W-1:0]   ch;
        logic [TICK_W-1:0]   now;
    } t_pat_req;

    // Pattern status after the step.
    typedef struct packed {
        t_mode               mode;
        logic [COUNT_W-1:0]  count;
        logic                wrote;
        logic [INDEX_W-1:0]  idx;
        logic [DUR_W-1:0]    dur;
    } t_pat_res;

endpackage

// ----- hw/rtl/dbp_in_if.sv -----
// ----------------------------------------------------------------------------
// Pin sample channel
// Valid/ready channel that carries one pin sample per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dbp_in_if;
    logic                            valid;
    logic                            ready;
    logic [dbp_pkg::TICK_W-1:0]      sample_tick;
    logic [dbp_pkg::CHAN_W-1:0]      channel;
    logic                            pin_level;

    modport source (output valid, output sample_tick, output channel, output pin_level,
                    input ready);
    modport sink (input valid, input sample_tick, input channel, input pin_level,
                  output ready);
endinterface

// ----- hw/rtl/dbp_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one debounce and pattern result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dbp_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      edge_event;
    logic [1:0]                      pattern_mode;
    logic [dbp_pkg::COUNT_W-1:0]     pattern_count;
    logic                            slot_written;
    logic [dbp_pkg::INDEX_W-1:0]     slot_index;
    logic [dbp_pkg::DUR_W-1:0]       slot_duration;

    modport source (output valid, output edge_event, output pattern_mode,
                    output pattern_count, output slot_written, output slot_index,
                    output slot_duration, input ready);
    modport sink (input valid, input edge_event, input pattern_mode,
                  input pattern_count, input slot_written, input slot_index,
                  input slot_duration, output ready);
endinterface

// ----- hw/rtl/debounce_with_pulse_pattern_timing.sv -----
// ----------------------------------------------------------------------------
// Debounce with pulse pattern timing
// Per-channel switch debounce with a shared pulse pattern recorder.
// ----------------------------------------------------------------------------
//
//   Port      Direction  Transfer content
//   i_smp     sink       sample_tick, channel, pin_level (one pin sample)
//   o_res     source     edge_event, pattern_mode, pattern_count,
//                        slot_written, slot_index, slot_duration
//   i_cfg_*   write      register index and 16-bit value, no read-back
//
// The block takes one sample per cycle while the result path is not stalled.
// The channel-state read starts at the transfer edge and its data arrive in
// the next cycle, in which the update stage computes the new state and
// pattern; the result register loads when that stage advances. A write
// forwarding path covers back-to-back samples of one channel. Reset clears the
// memory valid bits at once; a stalled result register holds the update stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounce_with_pulse_pattern_timing #(
    parameter int CHANNELS      = dbp_pkg::CHANNELS_DEF,
    parameter int PATTERN_SLOTS = dbp_pkg::PATTERN_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbp_in_if.sink                          i_smp,
    dbp_out_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [dbp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dbp_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers. They must only be written while the block is idle; the block itself does not enforce it.
    logic [dbp_pkg::CFG_W-1:0] r_debounce;
    logic [dbp_pkg::CFG_W-1:0] r_timeout;
    logic [dbp_pkg::CFG_W-1:0] r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= dbp_pkg::DEBOUNCE_RESET;
            r_timeout  <= dbp_pkg::TIMEOUT_RESET;
            r_enable   <= dbp_pkg::ENABLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dbp_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_wdata;
                dbp_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_wdata;
                dbp_pkg::CFG_ENABLE:   r_enable   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Update stage: the accepted sample waits here while its channel state
    // comes out of the memory.
    logic                          r_s1_valid;
    logic [dbp_pkg::TICK_W-1:0]    r_s1_tick;
    logic [dbp_pkg::CHAN_W-1:0]    r_s1_ch;
    logic                          r_s1_level;

    logic                          r_out_valid;
    logic                          w_advance;
    logic                          w_accept;

    assign w_advance   = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_smp.ready = !r_s1_valid || w_advance;
    assign w_accept    = i_smp.valid && i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_tick  <= i_smp.sample_tick;
            r_s1_ch    <= i_smp.channel;
            r_s1_level <= i_smp.pin_level;
        end
    end

    // Channel state memory, read on transfer and written when the update
    // stage moves the result of an in-range channel on.
    dbp_pkg::t_chan_state w_rd_state;
    dbp_pkg::t_chan_state w_nx_state;
    logic                 w_in_range;
    logic                 w_wr_en;

    assign w_in_range = ({1'b0, r_s1_ch} < (dbp_pkg::CHAN_W + 1)'(CHANNELS));
    assign w_wr_en    = w_advance && w_in_range;

    dbp_state_mem #(
        .CHANNELS (CHANNELS)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_smp.channel[AW-1:0]),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_ch[AW-1:0]),
        .i_wr_data (w_nx_state),
        .o_rd_data (w_rd_state)
    );

    // Debounce machine. A change of level arms a rising or falling phase; a
    // revert drops back at once; holding for the debounce time qualifies the
    // edge. An unknown phase code behaves as undetermined.
    logic [dbp_pkg::TICK_W-1:0] w_held;
    logic                       w_qualified;
    dbp_pkg::t_edge             w_edge;

    assign w_held      = r_s1_tick - w_rd_state.change_time;
    assign w_qualified = (w_held >= r_debounce);

    always_comb begin
        w_nx_state = w_rd_state;
        w_edge     = dbp_pkg::EV_NONE;
        if (r_s1_level) begin
            case (w_rd_state.phase)
                dbp_pkg::PH_LOW: begin
                    w_nx_state.phase       = dbp_pkg::PH_RISING;
                    w_nx_state.change_time = r_s1_tick;
                end
                dbp_pkg::PH_HIGH: begin
                    w_nx_state.phase = dbp_pkg::PH_HIGH;
                end
                dbp_pkg::PH_RISING: begin
                    if (w_qualified) begin
                        w_nx_state.phase = dbp_pkg::PH_HIGH;
                        w_edge           = dbp_pkg::EV_RISE;
                    end
                end
                default: begin
                    w_nx_state.phase = dbp_pkg::PH_HIGH;
                end
            endcase
        end else begin
            case (w_rd_state.phase)
                dbp_pkg::PH_HIGH: begin
                    w_nx_state.phase       = dbp_pkg::PH_FALLING;
                    w_nx_state.change_time = r_s1_tick;
                end
                dbp_pkg::PH_LOW: begin
                    w_nx_state.phase = dbp_pkg::PH_LOW;
                end
                dbp_pkg::PH_FALLING: begin
                    if (w_qualified) begin
                        w_nx_state.phase = dbp_pkg::PH_LOW;
                        w_edge           = dbp_pkg::EV_FALL;
                    end
                end
                default: begin
                    w_nx_state.phase = dbp_pkg::PH_LOW;
                end
            endcase
        end
    end

    // Shared pattern recorder. Its registers change only when the result
    // moves on, so consecutive samples always see an up-to-date pattern.
    dbp_pkg::t_pat_req w_req;
    dbp_pkg::t_pat_res w_pat;

    always_comb begin
        w_req.commit     = w_advance;
        w_req.in_range   = w_in_range;
        w_req.enabled    = r_enable[r_s1_ch];
        w_req.edge_hit   = (w_edge != dbp_pkg::EV_NONE);
        w_req.start_mode = (w_edge == dbp_pkg::EV_RISE) ? dbp_pkg::MODE_HIGH
                                                        : dbp_pkg::MODE_LOW;
        w_req.ch         = r_s1_ch;
        w_req.now        = r_s1_tick;
    end

    dbp_pattern #(
        .PATTERN_SLOTS (PATTERN_SLOTS)
    ) u_pattern (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_timeout (r_timeout),
        .o_res     (w_pat)
    );

    // Result register. It frees the update stage so that the next sample can
    // be taken while a finished result still waits for its transfer.
    dbp_pkg::t_edge    r_out_edge;
    dbp_pkg::t_pat_res r_out_pat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_edge <= w_in_range ? w_edge : dbp_pkg::EV_NONE;
            r_out_pat  <= w_pat;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.edge_event    = r_out_edge;
    assign o_res.pattern_mode  = r_out_pat.mode;
    assign o_res.pattern_count = r_out_pat.count;
    assign o_res.slot_written  = r_out_pat.wrote;
    assign o_res.slot_index    = r_out_pat.idx;
    assign o_res.slot_duration = r_out_pat.dur;

endmodule

// ----- hw/rtl/dbp_state_mem.sv -----
// ----------------------------------------------------------------------------
// Channel state memory
// Synchronous per-channel state store with valid bits and write forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbp_state_mem #(
    parameter int CHANNELS = dbp_pkg::CHANNELS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_rd_addr,
    input  logic                                   i_wr_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_wr_addr,
    input  dbp_pkg::t_chan_state                   i_wr_data,
    output dbp_pkg::t_chan_state                   o_rd_data
);

    dbp_pkg::t_chan_state r_mem [CHANNELS];
    logic [CHANNELS-1:0]  r_valid;

    dbp_pkg::t_chan_state r_rd;
    dbp_pkg::t_chan_state r_fwd;
    logic                 r_hit;
    logic                 r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // A read in the same cycle as a write to the same entry sees the old data,
    // so the written value is kept aside and chosen instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
                r_vld <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd <= i_wr_data;
        end
    end

    always_comb begin
        if (r_hit) begin
            o_rd_data = r_fwd;
        end else if (r_vld) begin
            o_rd_data = r_rd;
        end else begin
            o_rd_data = dbp_pkg::CHAN_RESET;
        end
    end

endmodule

// ----- hw/rtl/dbp_pattern.sv -----
// ----------------------------------------------------------------------------
// Pulse pattern unit
// Shared pattern recorder: start, append of edge durations, and timeout clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbp_pattern #(
    parameter int PATTERN_SLOTS = dbp_pkg::PATTERN_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dbp_pkg::t_pat_req             i_req,
    input  logic [dbp_pkg::CFG_W-1:0]     i_timeout,
    output dbp_pkg::t_pat_res             o_res
);

    dbp_pkg::t_mode                  r_mode, n_mode;
    logic [dbp_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [dbp_pkg::TICK_W-1:0]      r_last, n_last;
    logic [dbp_pkg::CHAN_W-1:0]      r_owner, n_owner;

    logic [dbp_pkg::TICK_W-1:0]      w_elapsed;
    logic [2*dbp_pkg::TICK_W-1:0]    w_prod;
    logic [dbp_pkg::TICK_W-1:0]      w_quiet;

    assign w_elapsed = i_req.now - r_last;
    assign w_prod    = 32'(w_elapsed) * 32'(dbp_pkg::DIV10_MUL);

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_last      = r_last;
        n_owner     = r_owner;
        o_res.wrote = 1'b0;
        o_res.idx   = '0;
        o_res.dur   = '0;

        if (i_req.in_range && i_req.enabled && i_req.edge_hit) begin
            n_owner = i_req.ch;
            if (r_mode != dbp_pkg::MODE_IDLE) begin
                if (r_count < dbp_pkg::COUNT_W'(PATTERN_SLOTS)) begin
                    o_res.wrote = 1'b1;
                    o_res.idx   = r_count[dbp_pkg::INDEX_W-1:0];
                    o_res.dur   = w_prod[dbp_pkg::DIV10_SHIFT +: dbp_pkg::DUR_W];
                    n_count     = r_count + 5'd1;
                end
            end else begin
                n_mode  = i_req.start_mode;
                n_count = '0;
            end
            n_last = i_req.now;
        end

        w_quiet = i_req.now - n_last;
        if (i_req.in_range && i_req.enabled && (n_owner == i_req.ch) &&
            (w_quiet > i_timeout)) begin
            n_count = '0;
            n_mode  = dbp_pkg::MODE_IDLE;
        end

        o_res.mode  = n_mode;
        o_res.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= dbp_pkg::MODE_IDLE;
            r_count <= '0;
            r_last  <= '0;
            r_owner <= '0;
        end else if (i_req.commit) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_last  <= n_last;
            r_owner <= n_owner;
        end
    end

endmodule

// ----- hw/rtl/dbp_checker.sv -----
// ----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the result stream of the debounce and pattern block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "debounce_with_pulse_pattern_timing_assert.svh"

module dbp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [1:0]                      i_edge_event,
    input  logic [1:0]                      i_pattern_mode,
    input  logic [dbp_pkg::COUNT_W-1:0]     i_pattern_count,
    input  logic                            i_slot_written,
    input  logic [dbp_pkg::INDEX_W-1:0]     i_slot_index,
    input  logic [dbp_pkg::DUR_W-1:0]       i_slot_duration
);

    logic [dbp_pkg::COUNT_W-1:0] w_next_count;
    assign w_next_count = {1'b0, i_slot_index} + 5'd1;

    // A stored duration always leaves an active pattern whose fill level is
    // one past the slot just written.
    `DBP_ASSERT(a_slot_count, i_clk, i_rst_n, (i_out_valid && i_slot_written) |-> ((i_pattern_count == w_next_count) && (i_pattern_mode != dbp_pkg::MODE_IDLE)), "slot write does not match pattern fill level")

    // Only a qualified edge can store a duration.
    `DBP_ASSERT(a_slot_needs_edge, i_clk, i_rst_n, (i_out_valid && i_slot_written) |-> (i_edge_event != dbp_pkg::EV_NONE), "slot written without a qualified edge")

    // Without a store the slot fields read as zero.
    `DBP_ASSERT(a_slot_idle_zero, i_clk, i_rst_n, (i_out_valid && !i_slot_written) |-> ((i_slot_index == '0) && (i_slot_duration == '0)), "slot fields not zero without a store")

    // A stalled result keeps its pattern count.
    `DBP_ASSERT_HOLD(a_hold_count, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_pattern_count, "pattern count changed while stalled")

endmodule

bind debounce_with_pulse_pattern_timing dbp_checker u_dbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_edge_event    (o_res.edge_event),
    .i_pattern_mode  (o_res.pattern_mode),
    .i_pattern_count (o_res.pattern_count),
    .i_slot_written  (o_res.slot_written),
    .i_slot_index    (o_res.slot_index),
    .i_slot_duration (o_res.slot_duration)
);
